### sv/filtered_trace_ring_buffer_macros.svh
// Assertion macros used by the checker file.
`ifndef FILTERED_TRACE_RING_BUFFER_MACROS_SVH
`define FILTERED_TRACE_RING_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ftrb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FTRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ftrb assertion failed");

`endif

### sv/ftrb_pkg.sv
package ftrb_pkg;

    localparam int MASK_W    = 32;
    localparam int CHAN_W    = 5;
    localparam int SEV_W     = 8;
    localparam int WORD_W    = 32;
    localparam int CODE_W    = 16;
    localparam int ENTRY_W   = 125;
    localparam int TDATA_W   = 128;
    localparam int S_TUSER_W = 1;
    localparam int M_TUSER_W = 3;

    localparam logic [MASK_W-1:0] MASK_RESET = 32'hFFFF_FFFF;

    // Request kinds carried in s_tuser and echoed in m_tuser.
    localparam logic REQ_EMIT  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Input word layout (s_tdata).
    localparam int IN_CHAN_LSB  = 0;
    localparam int IN_SEV_LSB   = 5;
    localparam int IN_FRAME_LSB = 13;
    localparam int IN_ADDR_LSB  = 45;
    localparam int IN_DATA_LSB  = 77;
    localparam int IN_CODE_LSB  = 109;

    // Stored entry and output word layout (m_tdata), lowest field first.
    localparam int OUT_FRAME_LSB = 0;
    localparam int OUT_ADDR_LSB  = 32;
    localparam int OUT_VALUE_LSB = 64;
    localparam int OUT_CODE_LSB  = 96;
    localparam int OUT_CHAN_LSB  = 112;
    localparam int OUT_SEV_LSB   = 117;

    // Bit positions in m_tuser.
    localparam int UB_KIND   = 0;
    localparam int UB_STORED = 1;
    localparam int UB_FOUND  = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } ftrb_state_t;

endpackage

### sv/ftrb_ram.sv
module ftrb_ram #(
    parameter int WIDTH = 125,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/filtered_trace_ring_buffer.sv
// Trace event ring buffer with a per-channel enable mask.
// Input words (s_*): s_tuser selects emit or query, s_tdata carries the event.
// An emit whose channel bit in the mask is set is written at the write pointer,
// overwriting the oldest entry once the buffer is full. A query searches the
// stored entries from the newest back to the oldest for its channel.
// Every input word yields exactly one result word on m_*.
// An emit, or a query on an empty buffer, goes from acceptance straight to the
// result state. Any other query first passes through the scan, which reads n
// entries, the match included (at most the occupancy, so at most DEPTH): the
// single read port of the event memory delivers one entry per cycle, newest
// first. The result state then loads the result into the output register as
// soon as that register is free.
// The block holds one word in flight; s_tready is high while it is idle.
// Results sit in an output register, so a new word is taken while an earlier
// result still waits; if the receiver stalls, the next result waits inside
// the block and s_tready stays low until it reaches the output register.
// Reset (synchronous, active low) empties the buffer, enables all channels
// and drops any result not yet taken. No memory clearing is needed.
// cfg_wr_en writes cfg_wr_data into the mask; write it only while idle.
module filtered_trace_ring_buffer #(
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ftrb_pkg::MASK_W-1:0]          cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // chan, sev, frame_no, addr_word, data_word, event_code, 3 zero bits
    input  logic [ftrb_pkg::TDATA_W-1:0]         s_tdata,
    // req_type
    input  logic [ftrb_pkg::S_TUSER_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_frame, out_addr, out_value, out_code, out_chan, out_sev, 3 zero bits
    output logic [ftrb_pkg::TDATA_W-1:0]         m_tdata,
    // resp_kind, stored, found
    output logic [ftrb_pkg::M_TUSER_W-1:0]       m_tuser
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    ftrb_pkg::ftrb_state_t state_reg, state_next;

    logic [ftrb_pkg::MASK_W-1:0]    mask_reg;
    logic [PTR_W-1:0]               wr_ptr_reg;
    logic [OCC_W-1:0]               occ_reg;
    logic [PTR_W-1:0]               rd_ptr_reg;
    logic [OCC_W-1:0]               left_reg;
    logic [ftrb_pkg::CHAN_W-1:0]    qchan_reg;
    logic                           res_kind_reg;
    logic                           res_stored_reg;
    logic                           res_found_reg;
    logic [ftrb_pkg::ENTRY_W-1:0]   res_data_reg;
    logic                           m_valid_reg;
    logic [ftrb_pkg::M_TUSER_W-1:0] m_user_reg;
    logic [ftrb_pkg::TDATA_W-1:0]   m_data_reg;

    logic                           accept;
    logic                           in_query;
    logic [ftrb_pkg::CHAN_W-1:0]    in_chan;
    logic                           chan_on;
    logic                           out_free;
    logic                           scan_hit;
    logic                           load_out;
    logic                           ram_we;
    logic [PTR_W-1:0]               ram_raddr;
    logic [PTR_W-1:0]               newest_ptr;
    logic [ftrb_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [ftrb_pkg::ENTRY_W-1:0]   ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? LAST_PTR : p - PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    assign accept     = s_tvalid && s_tready;
    assign in_query   = (s_tuser[0] == ftrb_pkg::REQ_QUERY);
    assign in_chan    = s_tdata[ftrb_pkg::IN_CHAN_LSB +: ftrb_pkg::CHAN_W];
    assign chan_on    = mask_reg[in_chan];
    assign out_free   = !m_valid_reg || m_tready;
    assign newest_ptr = ptr_dec(wr_ptr_reg);
    assign scan_hit   = (ram_rdata[ftrb_pkg::OUT_CHAN_LSB +: ftrb_pkg::CHAN_W] == qchan_reg);

    // Reorder the input fields into the output layout so a hit maps straight out.
    assign ram_wdata = {
        s_tdata[ftrb_pkg::IN_SEV_LSB   +: ftrb_pkg::SEV_W],
        s_tdata[ftrb_pkg::IN_CHAN_LSB  +: ftrb_pkg::CHAN_W],
        s_tdata[ftrb_pkg::IN_CODE_LSB  +: ftrb_pkg::CODE_W],
        s_tdata[ftrb_pkg::IN_DATA_LSB  +: ftrb_pkg::WORD_W],
        s_tdata[ftrb_pkg::IN_ADDR_LSB  +: ftrb_pkg::WORD_W],
        s_tdata[ftrb_pkg::IN_FRAME_LSB +: ftrb_pkg::WORD_W]
    };

    ftrb_ram #(
        .WIDTH (ftrb_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ftrb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_query && occ_reg != '0) begin
                        state_next = ftrb_pkg::ST_SCAN;
                    end else begin
                        state_next = ftrb_pkg::ST_RESP;
                    end
                end
            end
            ftrb_pkg::ST_SCAN: begin
                if (scan_hit || left_reg == '0) begin
                    state_next = ftrb_pkg::ST_RESP;
                end
            end
            ftrb_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = ftrb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ftrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        load_out  = 1'b0;
        ram_raddr = rd_ptr_reg;
        case (state_reg)
            ftrb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                ram_we   = accept && !in_query && chan_on;
                // The newest entry is fetched while a query is accepted.
                ram_raddr = newest_ptr;
            end
            ftrb_pkg::ST_SCAN: begin
                ram_raddr = rd_ptr_reg;
            end
            ftrb_pkg::ST_RESP: begin
                load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ftrb_pkg::ST_IDLE;
            mask_reg    <= ftrb_pkg::MASK_RESET;
            wr_ptr_reg  <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                mask_reg <= cfg_wr_data;
            end
            if (ram_we) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
                if (occ_reg != FULL_OCC) begin
                    occ_reg <= occ_reg + OCC_W'(1);
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_kind_reg   <= s_tuser[0];
            res_stored_reg <= !in_query && chan_on;
            res_found_reg  <= 1'b0;
            res_data_reg   <= '0;
            qchan_reg      <= in_chan;
            rd_ptr_reg     <= ptr_dec(newest_ptr);
            left_reg       <= occ_reg - OCC_W'(1);
        end else if (state_reg == ftrb_pkg::ST_SCAN) begin
            // The read data belongs to the address issued in the previous cycle.
            if (scan_hit) begin
                res_found_reg <= 1'b1;
                res_data_reg  <= ram_rdata;
            end else if (left_reg != '0) begin
                rd_ptr_reg <= ptr_dec(rd_ptr_reg);
                left_reg   <= left_reg - OCC_W'(1);
            end
        end
        if (load_out) begin
            m_user_reg <= {res_found_reg, res_stored_reg, res_kind_reg};
            m_data_reg <= {{(ftrb_pkg::TDATA_W - ftrb_pkg::ENTRY_W){1'b0}}, res_data_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

endmodule

### sv/ftrb_checker.sv
`include "filtered_trace_ring_buffer_macros.svh"

module ftrb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ftrb_pkg::TDATA_W-1:0]   m_tdata,
    input logic [ftrb_pkg::M_TUSER_W-1:0] m_tuser
);

    logic emit_out;
    logic query_out;

    assign emit_out  = m_tvalid && (m_tuser[ftrb_pkg::UB_KIND] == ftrb_pkg::REQ_EMIT);
    assign query_out = m_tvalid && (m_tuser[ftrb_pkg::UB_KIND] == ftrb_pkg::REQ_QUERY);

    // A stalled result word keeps its contents.
    `FTRB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // An emit reports only whether it was stored; its data word is all zero.
    `FTRB_ASSERT_NOW(a_emit_clean, aclk, aresetn, emit_out,
        !m_tuser[ftrb_pkg::UB_FOUND] && m_tdata == '0)

    // A query never claims to have stored anything.
    `FTRB_ASSERT_NOW(a_query_not_stored, aclk, aresetn, query_out,
        !m_tuser[ftrb_pkg::UB_STORED])

    // A query that missed returns an all-zero event.
    `FTRB_ASSERT_NOW(a_miss_zero, aclk, aresetn, query_out && !m_tuser[ftrb_pkg::UB_FOUND],
        m_tdata == '0)

    // Only one word is in flight: after an acceptance the input side is closed.
    `FTRB_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind filtered_trace_ring_buffer ftrb_checker u_ftrb_checker (.*);
